/* hw/rtl/qgd_pkg.sv */
// ----------------------------------------------------------------------------
// qgd_pkg - quartic gradient descent step shared definitions
// Q16.16 constants, opcode/status/register codes and saturation helpers.
// ----------------------------------------------------------------------------
package qgd_pkg;

  localparam logic signed [31:0] MAX32 = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MIN32 = 32'sh8000_0000;

  // Thresholds and scale factors, raw Q16.16
  localparam logic signed [31:0] Y_LOW_LIMIT    = -32'sd655360;
  localparam logic signed [31:0] Y_HIGH_LIMIT   = 32'sd1310720;
  localparam logic [22:0]        LEARN_FLOOR    = 23'd65;
  localparam logic [22:0]        LEARN_MAX      = 23'd6553600;
  localparam logic signed [31:0] LEARN_MAX_S32  = 32'sd6553600;
  localparam logic signed [31:0] SLOW_FACTOR    = 32'sd58982;

  // Coefficient reset values
  localparam logic signed [31:0] RST_QUARTIC  = 32'sd2048;
  localparam logic signed [31:0] RST_CUBIC    = 32'sd6144;
  localparam logic signed [31:0] RST_SQUARE   = -32'sd14336;
  localparam logic signed [31:0] RST_LINEAR   = 32'sd0;
  localparam logic signed [31:0] RST_CONSTANT = 32'sd0;

  // Opcodes
  localparam logic [1:0] OP_STEP      = 2'd0;
  localparam logic [1:0] OP_SET_POS   = 2'd1;
  localparam logic [1:0] OP_SET_LEARN = 2'd2;

  // Result status
  localparam logic [2:0] ST_TAKEN  = 3'd0;
  localparam logic [2:0] ST_LOW    = 3'd1;
  localparam logic [2:0] ST_SLOWED = 3'd2;
  localparam logic [2:0] ST_FLOOR  = 3'd3;
  localparam logic [2:0] ST_SET    = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_QUARTIC  = 3'd0;
  localparam logic [2:0] REG_CUBIC    = 3'd1;
  localparam logic [2:0] REG_SQUARE   = 3'd2;
  localparam logic [2:0] REG_LINEAR   = 3'd3;
  localparam logic [2:0] REG_CONSTANT = 3'd4;

  typedef struct packed {
    logic load;    // capture a new product
    logic negate;  // negate the scaled product before the add
  } qgd_alu_ctl_t;

  function automatic logic signed [31:0] sat48(input logic signed [47:0] v);
    if (v[47:31] == {17{v[31]}}) return v[31:0];
    else if (v[47]) return MIN32;
    else return MAX32;
  endfunction

  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    if (v[33:31] == {3{v[31]}}) return v[31:0];
    else if (v[33]) return MIN32;
    else return MAX32;
  endfunction

  function automatic logic signed [31:0] times4(input logic signed [31:0] a);
    return sat34({a, 2'b00});
  endfunction

  function automatic logic signed [31:0] times3(input logic signed [31:0] a);
    logic signed [33:0] ext;
    ext = {{2{a[31]}}, a};
    return sat34(ext + {ext[32:0], 1'b0});
  endfunction

  function automatic logic signed [31:0] times2(input logic signed [31:0] a);
    return sat34({a[31], a, 1'b0});
  endfunction

endpackage

/* hw/rtl/qgd_alu.sv */
// ----------------------------------------------------------------------------
// qgd_alu - shared multiply / scale / accumulate unit
// 32x32 signed product registered, then floor >>16, optional negate and a
// saturating add of the addend, each step saturated to 32 bits.
// ----------------------------------------------------------------------------
module qgd_alu (
  input  logic                    clk,
  input  qgd_pkg::qgd_alu_ctl_t   ctl,
  input  logic signed [31:0]      mul_a,
  input  logic signed [31:0]      mul_b,
  input  logic signed [31:0]      addend,
  output logic signed [31:0]      result
);

  logic signed [63:0] prod;
  logic signed [31:0] scaled;
  logic signed [31:0] term;
  logic signed [33:0] sum;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      prod <= mul_a * mul_b;
    end
  end

  always_comb begin
    // dropping the low 16 bits of a two's complement word rounds down
    scaled = qgd_pkg::sat48(prod[63:16]);
    if (ctl.negate) begin
      term = (scaled == qgd_pkg::MIN32) ? qgd_pkg::MAX32 : -scaled;
    end else begin
      term = scaled;
    end
    sum    = {{2{term[31]}}, term} + {{2{addend[31]}}, addend};
    result = qgd_pkg::sat34(sum);
  end

endmodule

/* hw/rtl/quartic_gradient_descent_step_unit.sv */
// ----------------------------------------------------------------------------
// quartic_gradient_descent_step_unit - gradient descent on a quartic, Q16.16
// Each multiply-accumulate goes through the one shared multiplier (S_MUL, then
// S_ADD); a new beat is taken the cycle after the result is posted, so only one
// item is in flight at a time, and a finished item waits in S_HOLD while the
// previous posted result waits for out_ready.
// Reset (synchronous): coefficients to defaults, position and learn rate 0.
// ----------------------------------------------------------------------------
module quartic_gradient_descent_step_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         opcode,
  input  logic signed [31:0] operand_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] position_out,
  output logic signed [31:0] value_out,
  output logic signed [31:0] slope_out,
  output logic [22:0]        learn_out,
  output logic [2:0]         step_status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_ADD, S_HOLD} state_t;
  typedef enum logic [2:0] {
    PH_SLOPE_OLD, PH_DELTA, PH_VALUE_NEW, PH_SLOW, PH_VALUE_OUT, PH_SLOPE_OUT
  } phase_t;

  state_t             state;
  phase_t             phase;
  logic [1:0]         k;
  logic               slope_after;
  logic signed [31:0] acc;
  logic signed [31:0] position;
  logic [22:0]        learn;
  logic signed [31:0] xnew;
  logic signed [31:0] slope_r;
  logic signed [31:0] value_r;
  logic [2:0]         status;

  logic signed [31:0] coeff_a, coeff_b, coeff_c, coeff_d, coeff_e;
  logic signed [31:0] a4, b3, c2;

  logic signed [31:0] mul_a, mul_b, addend, alu_r;
  logic               negate, last;
  logic [22:0]        learn_set;
  qgd_pkg::qgd_alu_ctl_t alu_ctl;

  assign in_ready  = (state == S_IDLE);
  // coefficients only change between items
  assign cfg_ready = (state == S_IDLE);

  assign a4 = qgd_pkg::times4(coeff_a);
  assign b3 = qgd_pkg::times3(coeff_b);
  assign c2 = qgd_pkg::times2(coeff_c);

  always_comb begin
    if (operand_value[31]) learn_set = '0;
    else if (operand_value > qgd_pkg::LEARN_MAX_S32) learn_set = qgd_pkg::LEARN_MAX;
    else learn_set = operand_value[22:0];
  end

  // Operand routing for the current Horner step, position update or rate slowdown
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    addend = '0;
    negate = 1'b0;
    last   = 1'b0;
    unique case (phase)
      PH_SLOPE_OLD, PH_SLOPE_OUT: begin
        mul_a = (k == 2'd0) ? a4 : acc;
        mul_b = position;
        unique case (k)
          2'd0:    addend = b3;
          2'd1:    addend = c2;
          default: addend = coeff_d;
        endcase
        last = (k == 2'd2);
      end
      PH_VALUE_NEW, PH_VALUE_OUT: begin
        mul_a = (k == 2'd0) ? coeff_a : acc;
        mul_b = (phase == PH_VALUE_NEW) ? xnew : position;
        unique case (k)
          2'd0: addend = coeff_b;
          2'd1: addend = coeff_c;
          2'd2: addend = coeff_d;
          2'd3: addend = coeff_e;
        endcase
        last = (k == 2'd3);
      end
      PH_DELTA: begin
        // x + sat(-(learn * slope))
        mul_a  = {9'd0, learn};
        mul_b  = slope_r;
        addend = position;
        negate = 1'b1;
        last   = 1'b1;
      end
      PH_SLOW: begin
        mul_a = {9'd0, learn};
        mul_b = qgd_pkg::SLOW_FACTOR;
        last  = 1'b1;
      end
      default: begin
        last = 1'b1;
      end
    endcase
  end

  assign alu_ctl.load   = (state == S_MUL);
  assign alu_ctl.negate = negate;

  qgd_alu u_alu (
    .clk    (clk),
    .ctl    (alu_ctl),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .addend (addend),
    .result (alu_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      phase       <= PH_SLOPE_OLD;
      k           <= '0;
      slope_after <= 1'b0;
      position    <= '0;
      learn       <= '0;
      out_valid   <= 1'b0;
      coeff_a     <= qgd_pkg::RST_QUARTIC;
      coeff_b     <= qgd_pkg::RST_CUBIC;
      coeff_c     <= qgd_pkg::RST_SQUARE;
      coeff_d     <= qgd_pkg::RST_LINEAR;
      coeff_e     <= qgd_pkg::RST_CONSTANT;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          qgd_pkg::REG_QUARTIC:  coeff_a <= cfg_data;
          qgd_pkg::REG_CUBIC:    coeff_b <= cfg_data;
          qgd_pkg::REG_SQUARE:   coeff_c <= cfg_data;
          qgd_pkg::REG_LINEAR:   coeff_d <= cfg_data;
          qgd_pkg::REG_CONSTANT: coeff_e <= cfg_data;
          default: ;
        endcase
      end

      // in S_HOLD the output register is reloaded below instead
      if (out_valid && out_ready && state != S_HOLD) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            k     <= '0;
            state <= S_MUL;
            case (opcode)
              qgd_pkg::OP_STEP: begin
                phase       <= PH_SLOPE_OLD;
                slope_after <= 1'b0;
              end
              qgd_pkg::OP_SET_POS: begin
                position    <= operand_value;
                status      <= qgd_pkg::ST_SET;
                phase       <= PH_VALUE_OUT;
                slope_after <= 1'b1;
              end
              qgd_pkg::OP_SET_LEARN: begin
                learn       <= learn_set;
                status      <= qgd_pkg::ST_SET;
                phase       <= PH_VALUE_OUT;
                slope_after <= 1'b1;
              end
              default: begin
                status      <= qgd_pkg::ST_SET;
                phase       <= PH_VALUE_OUT;
                slope_after <= 1'b1;
              end
            endcase
          end
        end
        S_MUL: begin
          state <= S_ADD;
        end
        S_ADD: begin
          acc   <= alu_r;
          state <= S_MUL;
          if (!last) begin
            k <= k + 2'd1;
          end else begin
            k <= '0;
            unique case (phase)
              PH_SLOPE_OLD: begin
                slope_r <= alu_r;
                phase   <= PH_DELTA;
              end
              PH_DELTA: begin
                xnew  <= alu_r;
                phase <= PH_VALUE_NEW;
              end
              PH_VALUE_NEW: begin
                // low limit is tested before the high one
                priority if (alu_r < qgd_pkg::Y_LOW_LIMIT) begin
                  status <= qgd_pkg::ST_LOW;
                  phase  <= PH_VALUE_OUT;
                end else if (alu_r > qgd_pkg::Y_HIGH_LIMIT) begin
                  if (learn > qgd_pkg::LEARN_FLOOR) begin
                    status <= qgd_pkg::ST_SLOWED;
                    phase  <= PH_SLOW;
                  end else begin
                    status <= qgd_pkg::ST_FLOOR;
                    phase  <= PH_VALUE_OUT;
                  end
                end else begin
                  position <= xnew;
                  value_r  <= alu_r;
                  status   <= qgd_pkg::ST_TAKEN;
                  phase    <= PH_SLOPE_OUT;
                end
              end
              PH_SLOW: begin
                learn <= alu_r[22:0];
                phase <= PH_VALUE_OUT;
              end
              PH_VALUE_OUT: begin
                value_r <= alu_r;
                if (slope_after) phase <= PH_SLOPE_OUT;
                else state <= S_HOLD;
              end
              PH_SLOPE_OUT: begin
                slope_r <= alu_r;
                state   <= S_HOLD;
              end
              default: ;
            endcase
          end
        end
        S_HOLD: begin
          if (!out_valid || out_ready) begin
            position_out <= position;
            value_out    <= value_r;
            slope_out    <= slope_r;
            learn_out    <= learn;
            step_status  <= status;
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

/* hw/rtl/qgd_checker.sv */
// ----------------------------------------------------------------------------
// qgd_checker - port-level checks for the quartic descent step unit
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
module qgd_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [22:0]        learn_out,
  input logic [2:0]         step_status
);

  // result beat stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before it was taken");

  // one item at a time: busy straight after an input beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  // a result is only posted at the end of a busy period
  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result posted without an item in flight");

  a_learn_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (learn_out <= qgd_pkg::LEARN_MAX) && (step_status <= qgd_pkg::ST_SET))
    else $error("learn rate or status out of range");

endmodule

bind quartic_gradient_descent_step_unit qgd_checker u_qgd_checker (.*);
